@@ design/ffud_pkg.sv @@
// shared types and constants for the fixed-frame uart deframer
// no dependencies
package ffud_pkg;

  localparam int unsigned CFG_INDEX_W = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL = 2'd1;

  localparam logic [7:0] HEAD_RESET = 8'h5B;
  localparam logic [7:0] TAIL_RESET = 8'hA5;
  localparam logic [6:0] CONF_MAX   = 7'd100;

  typedef struct packed {
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [15:0] command;
    logic [7:0]  class_code;
    logic [6:0]  confidence_percent;
    logic        confidence_clipped;
  } result_t;

endpackage

@@ design/ffud_in_stage.sv @@
// input register of the deframer: holds one received byte for the window stage
// depends on ffud_pkg
module ffud_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           rx_valid,
  output logic           rx_ready,
  input  logic [7:0]     rx_byte,
  input  logic           step,
  output logic           q_valid,
  output ffud_pkg::item_t item
);
  import ffud_pkg::*;

  // a held byte leaves in the same cycle a new one may enter
  assign rx_ready = !q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      q_valid <= 1'b1;
    end else if (step) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      item.rx_byte <= rx_byte;
    end
  end

endmodule

@@ design/ffud_core.sv @@
// window stage: gathers bytes from a head, checks the tail, realigns on a bad tail
// depends on ffud_pkg
module ffud_core #(
  parameter int unsigned FRAME_LENGTH = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  ffud_pkg::item_t  item,
  input  logic [7:0]       head,
  input  logic [7:0]       tail,
  output logic             hit,
  output ffud_pkg::result_t result
);
  import ffud_pkg::*;

  localparam int unsigned FillW  = $clog2(FRAME_LENGTH);
  localparam int unsigned ExtLen = FRAME_LENGTH + 4;

  logic [7:0]       window      [FRAME_LENGTH-1];
  logic [7:0]       window_next [FRAME_LENGTH-1];
  logic [FillW-1:0] fill;
  logic [FillW-1:0] fill_next;

  logic [7:0]       frame [FRAME_LENGTH];
  logic [7:0]       pay   [ExtLen];
  logic             full;
  logic             open_ok;
  logic             found;
  logic [FillW-1:0] k_sel;
  logic [7:0]       conf;
  logic             clipped;

  // frame as it would be with the new byte appended at the fill position
  always_comb begin
    for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
      frame[i] = (FillW'(i) < fill) ? window[i] : item.rx_byte;
    end
    frame[FRAME_LENGTH-1] = item.rx_byte;
  end

  assign full    = (fill == FillW'(FRAME_LENGTH - 1));
  assign open_ok = (fill != '0) || (item.rx_byte == head);
  assign hit     = full && (item.rx_byte == tail);

  // first head byte after the dropped byte, the new byte included
  always_comb begin
    found = 1'b0;
    k_sel = '0;
    for (int k = FRAME_LENGTH - 1; k >= 1; k--) begin
      if (frame[k] == head) begin
        found = 1'b1;
        k_sel = FillW'(k);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
      window_next[i] = window[i];
    end
    fill_next = fill;
    if (open_ok) begin
      if (!full) begin
        for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
          if (FillW'(i) == fill) begin
            window_next[i] = item.rx_byte;
          end
        end
        fill_next = fill + 1'b1;
      end else if (hit) begin
        fill_next = '0;
      end else if (found) begin
        for (int k = 1; k < FRAME_LENGTH; k++) begin
          if (k_sel == FillW'(k)) begin
            for (int i = 0; i < FRAME_LENGTH - k; i++) begin
              window_next[i] = frame[i+k];
            end
          end
        end
        fill_next = FillW'(FRAME_LENGTH) - k_sel;
      end else begin
        fill_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (step) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
        window[i] <= window_next[i];
      end
    end
  end

  // payload slots, zero where a short frame has no room for them
  always_comb begin
    for (int i = 0; i < ExtLen; i++) begin
      pay[i] = 8'd0;
    end
    for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
      pay[i] = frame[i];
    end
  end

  assign conf    = pay[4];
  assign clipped = (conf > {1'b0, CONF_MAX});

  assign result.command            = {pay[1], pay[2]};
  assign result.class_code         = pay[3];
  assign result.confidence_percent = clipped ? CONF_MAX : conf[6:0];
  assign result.confidence_clipped = clipped;

endmodule

@@ design/ffud_out_stage.sv @@
// result register of the deframer with its valid flag
// depends on ffud_pkg
module ffud_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ffud_pkg::result_t result,
  output logic              free,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [15:0]       command,
  output logic [7:0]        class_code,
  output logic [6:0]        confidence_percent,
  output logic              confidence_clipped
);
  import ffud_pkg::*;

  result_t held;

  assign free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign command            = held.command;
  assign class_code         = held.class_code;
  assign confidence_percent = held.confidence_percent;
  assign confidence_clipped = held.confidence_clipped;

endmodule

@@ design/fixed_frame_uart_deframer.sv @@
// top level of the fixed-frame uart deframer: config registers and stage wiring
// depends on ffud_pkg, ffud_in_stage, ffud_core, ffud_out_stage
//
// usage
//   rx channel (rx_valid/rx_ready/rx_byte): one received byte per transfer
//   res channel (res_valid/res_ready + fields): one transfer per good frame
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 head byte,
//     index 1 tail byte, other indexes ignored; always ready, write when idle
//   a frame is head, command high, command low, class, confidence, tail;
//   bytes ahead of a head are dropped, a bad tail drops the first held byte
//   and restarts at the next head byte, held or new
//   path: a frame's closing byte is held in the input register, then its result
//     is registered in the result register
//   throughput: one byte per cycle while the result register is free; the window
//     is updated between the input register and the result register
//   reset: window empty, head 0x5B, tail 0xA5, no result pending
//   receiver stall: the result register holds; the input register keeps one
//     byte, and rx_ready falls until the result is taken
module fixed_frame_uart_deframer #(
  parameter int unsigned FRAME_LENGTH = 6
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ffud_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             rx_valid,
  output logic                             rx_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [15:0]                      command,
  output logic [7:0]                       class_code,
  output logic [6:0]                       confidence_percent,
  output logic                             confidence_clipped
);
  import ffud_pkg::*;

  logic [7:0] head;
  logic [7:0] tail;
  logic       q_valid;
  item_t      item;
  logic       out_free;
  logic       step;
  logic       hit;
  result_t    result;

  // config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= HEAD_RESET;
      tail <= TAIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEAD: head <= cfg_data;
        REG_TAIL: tail <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a held byte is processed once the result slot can take any frame it closes
  assign step = q_valid && out_free;

  ffud_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_byte  (rx_byte),
    .step     (step),
    .q_valid  (q_valid),
    .item     (item)
  );

  ffud_core #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .head   (head),
    .tail   (tail),
    .hit    (hit),
    .result (result)
  );

  ffud_out_stage u_out (
    .clk                (clk),
    .rst                (rst),
    .load               (step && hit),
    .result             (result),
    .free               (out_free),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .command            (command),
    .class_code         (class_code),
    .confidence_percent (confidence_percent),
    .confidence_clipped (confidence_clipped)
  );

  // a good frame always lands in the result register
  a_frame_lands: assert property (@(posedge clk) disable iff (rst)
    step && hit |=> res_valid)
    else $error("good frame did not reach the result register");

  a_conf_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> confidence_percent <= CONF_MAX)
    else $error("confidence above saturation limit");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && confidence_clipped |-> confidence_percent == CONF_MAX)
    else $error("clipped confidence not at saturation limit");

  // a byte waiting in the input register is never dropped while stalled
  a_hold_byte: assert property (@(posedge clk) disable iff (rst)
    q_valid && !step |=> q_valid && item == $past(item))
    else $error("stalled input byte lost");

endmodule
